// ===== hdl/b64d_pkg.sv =====
package b64d_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueIdxW  = $clog2(QueueDepth);

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusCount = 2'd1;
  localparam logic [1:0] StatusPad   = 2'd2;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        has_status;
    logic [1:0]  status;
  } job_t;

  typedef struct packed {
    logic       is_sym;
    logic       is_pad;
    logic [5:0] value;
  } sym_t;

  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t s;
    s.is_sym = 1'b1;
    s.is_pad = 1'b0;
    s.value  = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      s.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.value = 6'd62;
    end else if (c == 8'h2F) begin
      s.value = 6'd63;
    end else if (c == PadChar) begin
      s.is_pad = 1'b1;
    end else begin
      s.is_sym = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== hdl/b64d_front.sv =====
module b64d_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     char_in_i,
  input  logic           final_char_i,
  output logic           push_o,
  output b64d_pkg::job_t job_o
);
  import b64d_pkg::*;

  logic [17:0] group_q, group_d;
  logic [1:0]  slot_q, slot_d;
  logic [2:0]  pad_q, pad_d;
  logic        after_pad_q, after_pad_d;
  logic        pad_err_q, pad_err_d;
  logic [1:0]  vmf_q, vmf_d;
  logic        any_q, any_d;
  sym_t        sym;
  logic [2:0]  pad_new;

  always_comb begin
    sym         = sym_decode(char_in_i);
    group_d     = group_q;
    slot_d      = slot_q;
    pad_d       = pad_q;
    after_pad_d = after_pad_q;
    pad_err_d   = pad_err_q;
    vmf_d       = vmf_q;
    any_d       = any_q;
    pad_new     = pad_q;
    job_o       = '0;
    if (sym.is_sym) begin
      any_d = 1'b1;
      vmf_d = vmf_q + 2'd1;
      if (!after_pad_q) begin
        if (sym.is_pad && pad_q < 3'd4) begin
          pad_new = pad_q + 3'd1;
        end
        pad_d = pad_new;
        if (slot_q < 2'd3) begin
          group_d = {group_q[11:0], sym.value};
          slot_d  = slot_q + 2'd1;
        end else begin
          job_o.word = {group_q, sym.value};
          case (pad_new)
            3'd0: job_o.nbytes = 2'd3;
            3'd1: job_o.nbytes = 2'd2;
            3'd2: job_o.nbytes = 2'd1;
            default: pad_err_d = 1'b1;
          endcase
          if (pad_new != 3'd0) begin
            after_pad_d = 1'b1;
          end
          group_d = '0;
          slot_d  = '0;
          pad_d   = '0;
        end
      end
    end
    if (final_char_i) begin
      job_o.has_status = 1'b1;
      if (!any_d || vmf_d != 2'd0) begin
        job_o.status = StatusCount;
      end else if (pad_err_d) begin
        job_o.status = StatusPad;
      end else begin
        job_o.status = StatusOk;
      end
      group_d     = '0;
      slot_d      = '0;
      pad_d       = '0;
      after_pad_d = 1'b0;
      pad_err_d   = 1'b0;
      vmf_d       = '0;
      any_d       = 1'b0;
    end
    push_o = accept_i && (job_o.nbytes != 2'd0 || job_o.has_status);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q     <= '0;
      slot_q      <= '0;
      pad_q       <= '0;
      after_pad_q <= 1'b0;
      pad_err_q   <= 1'b0;
      vmf_q       <= '0;
      any_q       <= 1'b0;
    end else if (accept_i) begin
      group_q     <= group_d;
      slot_q      <= slot_d;
      pad_q       <= pad_d;
      after_pad_q <= after_pad_d;
      pad_err_q   <= pad_err_d;
      vmf_q       <= vmf_d;
      any_q       <= any_d;
    end
  end

endmodule

// ===== hdl/b64d_fifo.sv =====
module b64d_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output b64d_pkg::job_t job_o
);
  import b64d_pkg::*;

  job_t                  mem_q [QueueDepth];
  logic [QueueIdxW-1:0]  wr_q, rd_q;
  logic [QueueIdxW:0]    cnt_q;

  assign full_o  = (cnt_q == (QueueIdxW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QueueIdxW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QueueIdxW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QueueIdxW+1)'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - (QueueIdxW+1)'(1);
      end
    end
  end

endmodule

// ===== hdl/b64d_back.sv =====
module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  b64d_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           item_kind_o,
  output logic [7:0]     data_byte_o,
  output logic [1:0]     status_o,
  output logic           last_result_o
);
  import b64d_pkg::*;

  job_t       cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] byte_q;
  logic [1:0] status_q;
  logic       last_q;

  logic       emit;
  logic       job_end;
  logic [2:0] total;
  logic       is_data;
  logic [7:0] byte_sel;

  always_comb begin
    total   = {1'b0, cur_q.nbytes} + {2'b00, cur_q.has_status};
    emit    = cur_valid_q && (!out_valid_q || out_ready_i);
    job_end = emit && (({1'b0, idx_q} + 3'd1) == total);
    pop_o   = job_valid_i && (!cur_valid_q || job_end);
    is_data = (idx_q < cur_q.nbytes);
    case (idx_q)
      2'd0:    byte_sel = cur_q.word[23:16];
      2'd1:    byte_sel = cur_q.word[15:8];
      2'd2:    byte_sel = cur_q.word[7:0];
      default: byte_sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
    if (emit) begin
      kind_q   <= is_data ? KindData : KindStatus;
      byte_q   <= is_data ? byte_sel : 8'd0;
      status_q <= is_data ? StatusOk : cur_q.status;
      last_q   <= !is_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (job_end) begin
        cur_valid_q <= 1'b0;
        idx_q       <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 2'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign item_kind_o   = kind_q;
  assign data_byte_o   = byte_q;
  assign status_o      = status_q;
  assign last_result_o = last_q;

endmodule

// ===== hdl/base64_decoder_core.sv =====
// Streaming base64 decoder, standard alphabet, one character per input item.
// A character is accepted in every cycle in which the four-entry job queue
// has room; each character produces zero to three data bytes and, when
// final_char_i is set, one status item after them. Results leave one per
// cycle from a registered output stage while out_ready_i is high, so the
// sustained input rate is one character per cycle as long as the results
// per character average at most one; the output port is what sets that
// limit. A result passes from the job queue through the current-job register
// to the output register before it is presented.
module base64_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       final_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       item_kind_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] status_o,
  output logic       last_result_o
);
  import b64d_pkg::*;

  logic accept;
  logic push;
  logic full;
  logic q_valid;
  logic pop;
  job_t job_in;
  job_t job_out;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .char_in_i    (char_in_i),
    .final_char_i (final_char_i),
    .push_o       (push),
    .job_o        (job_in)
  );

  b64d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .job_o   (job_out)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (job_out),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .item_kind_o   (item_kind_o),
    .data_byte_o   (data_byte_o),
    .status_o      (status_o),
    .last_result_o (last_result_o)
  );

endmodule
